@@ rtl/shape_curve_min_width_merge_top_macros.svh @@
// Assertion macros used by the shape curve merge top level.
`ifndef SHAPE_CURVE_MIN_WIDTH_MERGE_TOP_MACROS_SVH
`define SHAPE_CURVE_MIN_WIDTH_MERGE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCM_ASSERT(lbl, prop, msg)
`define SCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/scm_pkg.sv @@
// Package with the sizes and types of the shape curve merge block.
package scm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int DATA_W = 16;

  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  valid;
    data_t height;
    data_t width;
  } entry_t;

  typedef struct packed {
    logic  merge;
    logic  insert;
    logic  shift_out;
    data_t width;
    data_t height;
  } cmd_t;

endpackage

@@ rtl/shape_curve_min_width_merge_top.sv @@
// Top level of the shape curve merge: cell chain, drain control and output register.
//
// Usage:
// Points arrive on the in_ channel (in_valid/in_stall), one transaction per
// point, as (in_point_width, in_point_height) with in_final_point on the last
// point of a run. Each point is merged into a chain of MAX_POINTS cells kept
// sorted by height, so points are taken at one per cycle outside the drain.
// The point flagged final is merged too; then in_stall rises and the chain
// drains through cell 0 into the output register, one result per cycle in
// ascending height order, with out_last on the final result and
// out_overflowed on every result of a run that dropped a new height.
// The output register lets the first point of the next run enter while the
// last result of the previous run still waits.
// A stalled result holds on the out_ ports; the drain pauses with it.
// Reset (synchronous, rst_n low) empties the chain, clears the overflow flag
// and the output valid flag; no clearing pass is needed.
module shape_curve_min_width_merge_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_point_width,
  input  logic [15:0]          in_point_height,
  input  logic                 in_final_point,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_width,
  output logic [15:0]          out_height,
  output logic                 out_last,
  output logic                 out_overflowed
);

  `include "shape_curve_min_width_merge_top_macros.svh"

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                      state_r;
  logic                      state_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_last_r;
  logic                      out_ovf_r;
  scm_pkg::data_t            out_width_r;
  scm_pkg::data_t            out_height_r;

  scm_pkg::cmd_t             cmd;
  scm_pkg::entry_t           ent     [scm_pkg::MAX_POINTS];
  scm_pkg::entry_t           left_ent [scm_pkg::MAX_POINTS];
  scm_pkg::entry_t           right_ent[scm_pkg::MAX_POINTS];
  logic [scm_pkg::MAX_POINTS-1:0] lt_vec;
  logic [scm_pkg::MAX_POINTS-1:0] eq_vec;
  logic [scm_pkg::MAX_POINTS-1:0] left_lt;
  logic [scm_pkg::MAX_POINTS-1:0] valid_vec;

  logic in_acc;
  logic hit;
  logic full;
  logic pop;
  logic tail;

  assign in_stall = (state_r == ST_DRAIN);
  assign in_acc   = in_valid && !in_stall;
  assign hit      = |eq_vec;
  assign full     = valid_vec[scm_pkg::MAX_POINTS-1];
  assign pop      = (state_r == ST_DRAIN) && (!out_valid_r || !out_stall);
  // The entry leaving cell 0 is the last one when cell 1 is empty.
  assign tail     = !valid_vec[1];

  assign cmd.merge     = in_acc;
  assign cmd.insert    = in_acc && !hit && !full;
  assign cmd.shift_out = pop;
  assign cmd.width     = in_point_width;
  assign cmd.height    = in_point_height;

  for (genvar i = 0; i < scm_pkg::MAX_POINTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_lt[i]  = 1'b1;
      assign left_ent[i] = '0;
    end else begin : g_body
      assign left_lt[i]  = lt_vec[i-1];
      assign left_ent[i] = ent[i-1];
    end
    if (i == scm_pkg::MAX_POINTS - 1) begin : g_tail
      assign right_ent[i] = '0;
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end
    assign valid_vec[i] = ent[i].valid;

    scm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_lt   (left_lt[i]),
      .left_ent  (left_ent[i]),
      .right_ent (right_ent[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .ent       (ent[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!hit && full) begin
            ovf_nxt = 1'b1;
          end
          if (in_final_point) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          out_valid_nxt = 1'b1;
          if (tail) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_width_r  <= ent[0].width;
      out_height_r <= ent[0].height;
      out_last_r   <= tail;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_width      = out_width_r;
  assign out_height     = out_height_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

  // Occupied cells always form a prefix of the chain.
  `SCM_ASSERT(a_prefix, (((valid_vec >> 1) & ~valid_vec) == '0), "chain has a gap")
  // The two head cells, when both occupied, hold strictly rising heights.
  `SCM_ASSERT(a_sorted, (valid_vec[1] |-> (ent[0].height < ent[1].height)), "chain unsorted")
  // While draining, the head cell holds an entry.
  `SCM_ASSERT(a_drain_nonempty, ((state_r == ST_DRAIN) |-> valid_vec[0]), "drain of empty chain")
  // A final point closes the input until the drain is done.
  `SCM_ASSERT(a_final_stall, ((in_acc && in_final_point) |=> in_stall), "no drain after final")

endmodule

@@ rtl/scm_cell.sv @@
// One cell of the sorted insertion chain: holds one (height, width) entry.
module scm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  scm_pkg::cmd_t   cmd,
  input  logic            left_lt,
  input  scm_pkg::entry_t left_ent,
  input  scm_pkg::entry_t right_ent,
  output logic            lt,
  output logic            eq,
  output scm_pkg::entry_t ent
);

  logic            valid_r;
  logic            valid_nxt;
  scm_pkg::data_t  height_r;
  scm_pkg::data_t  height_nxt;
  scm_pkg::data_t  width_r;
  scm_pkg::data_t  width_nxt;

  assign lt = valid_r && (height_r < cmd.height);
  assign eq = valid_r && (height_r == cmd.height);

  assign ent.valid  = valid_r;
  assign ent.height = height_r;
  assign ent.width  = width_r;

  always_comb begin
    valid_nxt  = valid_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    if (cmd.shift_out) begin
      valid_nxt  = right_ent.valid;
      height_nxt = right_ent.height;
      width_nxt  = right_ent.width;
    end else if (cmd.merge && eq) begin
      if (cmd.width < width_r) begin
        width_nxt = cmd.width;
      end
    end else if (cmd.insert && !lt) begin
      // The first cell that is empty or holds a greater height takes the point; the
      // cells behind it move one place toward the tail.
      if (left_lt) begin
        valid_nxt  = 1'b1;
        height_nxt = cmd.height;
        width_nxt  = cmd.width;
      end else begin
        valid_nxt  = left_ent.valid;
        height_nxt = left_ent.height;
        width_nxt  = left_ent.width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    height_r <= height_nxt;
    width_r  <= width_nxt;
  end

endmodule

@@ sim/shape_curve_min_width_merge_top_tb.sv @@
// Self-checking testbench for the shape curve min-width merge block.
module shape_curve_min_width_merge_top_tb;

  typedef struct packed {
    scm_pkg::data_t width;
    scm_pkg::data_t height;
    logic           last;
    logic           overflowed;
  } result_t;

  // One directed transaction; the expected result is typed in only for
  // single-point runs, where it is the point itself.
  typedef struct packed {
    scm_pkg::data_t width;
    scm_pkg::data_t height;
    logic           final_pt;
    logic           typed;
    scm_pkg::data_t exp_width;
    scm_pkg::data_t exp_height;
  } stim_row_t;

  localparam int NUM_ROWS = 20;
  localparam int OVF_POINTS = scm_pkg::MAX_POINTS + 2;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  scm_pkg::data_t in_point_width = '0;
  scm_pkg::data_t in_point_height = '0;
  logic           in_final_point = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  scm_pkg::data_t out_width;
  scm_pkg::data_t out_height;
  logic           out_last;
  logic           out_overflowed;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int phase_items = 0;
  int mismatch_count = 0;

  // Predicted state of the sorted curve store.
  scm_pkg::data_t curve_heights [scm_pkg::MAX_POINTS];
  scm_pkg::data_t curve_widths [scm_pkg::MAX_POINTS];
  int             curve_used = 0;
  logic           curve_dropped = 1'b0;

  result_t expected_results [$];
  result_t head;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 16'h0000},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 16'hFFFF},
    '{16'd100,  16'd30,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd200,  16'd10,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd50,   16'd20,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd80,   16'd10,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd300,  16'd20,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd7,    16'd30,   1'b1, 1'b0, 16'h0000, 16'h0000},
    '{16'hAAAA, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h5555, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h0001, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{16'd500,  16'd42,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd500,  16'd42,   1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd499,  16'd42,   1'b1, 1'b0, 16'h0000, 16'h0000},
    '{16'd1,    16'd1,    1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd2,    16'd2,    1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'd3,    16'd3,    1'b1, 1'b0, 16'h0000, 16'h0000}
  };

  shape_curve_min_width_merge_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_width (in_point_width),
    .in_point_height(in_point_height),
    .in_final_point (in_final_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_last       (out_last),
    .out_overflowed (out_overflowed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Merges one point into the predicted store; a final point also empties
  // the store into the list of results it returns.
  function automatic void curve_step(input scm_pkg::data_t w, input scm_pkg::data_t h,
                                     input logic fin, output result_t res [$]);
    int      pos;
    result_t item;
    res = {};
    pos = 0;
    while (pos < curve_used && curve_heights[pos] < h) pos++;
    if (pos < curve_used && curve_heights[pos] == h) begin
      if (w < curve_widths[pos]) curve_widths[pos] = w;
    end else if (curve_used >= scm_pkg::MAX_POINTS) begin
      curve_dropped = 1'b1;
    end else begin
      for (int k = curve_used; k > pos; k--) begin
        curve_heights[k] = curve_heights[k-1];
        curve_widths[k] = curve_widths[k-1];
      end
      curve_heights[pos] = h;
      curve_widths[pos] = w;
      curve_used++;
    end
    if (fin) begin
      for (int i = 0; i < curve_used; i++) begin
        item.width = curve_widths[i];
        item.height = curve_heights[i];
        item.last = (i == curve_used - 1);
        item.overflowed = curve_dropped;
        res.insert(res.size(), item);
      end
      curve_used = 0;
      curve_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one point, waits for the transaction, then records what it causes.
  task automatic feed_point(input scm_pkg::data_t w, input scm_pkg::data_t h,
                            input logic fin, input logic typed,
                            input scm_pkg::data_t exp_w, input scm_pkg::data_t exp_h);
    result_t res [$];
    result_t exp_item;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_width <= w;
    in_point_height <= h;
    in_final_point <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    curve_step(w, h, fin, res);
    if (typed) begin
      exp_item.width = exp_w;
      exp_item.height = exp_h;
      exp_item.last = 1'b1;
      exp_item.overflowed = 1'b0;
      expected_results.insert(expected_results.size(), exp_item);
    end else begin
      foreach (res[i]) expected_results.insert(expected_results.size(), res[i]);
    end
    phase_items++;
  endtask

  task automatic random_curve(input int n_points);
    logic           narrow;
    scm_pkg::data_t w;
    scm_pkg::data_t h;
    // Narrow heights give many repeated heights within one run.
    narrow = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n_points; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          w = '0;
        end
        1: begin
          w = '1;
        end
        default: begin
          w = scm_pkg::data_t'($urandom_range(0, 65535));
        end
      endcase
      h = narrow ? scm_pkg::data_t'($urandom_range(0, 15))
                 : scm_pkg::data_t'($urandom_range(0, 65535));
      feed_point(w, h, i == n_points - 1, 1'b0, '0, '0);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result width %0d height %0d with nothing expected",
                                  out_width, out_height));
      end else begin
        head = expected_results.pop_front();
        if (out_width !== head.width)
          report_mismatch($sformatf("width %0d, expected %0d", out_width, head.width));
        if (out_height !== head.height)
          report_mismatch($sformatf("height %0d, expected %0d", out_height, head.height));
        if (out_last !== head.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, head.last));
        if (out_overflowed !== head.overflowed)
          report_mismatch($sformatf("overflowed %b, expected %b", out_overflowed,
                                    head.overflowed));
      end
    end
  end

  initial begin
    int ovf_base;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26;
    recv_stall_pct = 49;
    for (int r = 0; r < NUM_ROWS; r++) begin
      feed_point(directed_rows[r].width, directed_rows[r].height, directed_rows[r].final_pt,
                 directed_rows[r].typed, directed_rows[r].exp_width,
                 directed_rows[r].exp_height);
    end
    for (int phase = 0; phase < 3; phase++) begin
      phase_items = 0;
      if (phase == 1) begin
        send_idle_pct = 49;
        recv_stall_pct = 26;
        // A long hold on the results while points keep coming fills the
        // output path and forces the block to stall its input.
        hold_cycles = 300;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // More distinct heights than the store holds; the extra heights are
        // dropped, then points on kept heights must still merge.
        ovf_base = $urandom_range(0, 65535 - 3 * OVF_POINTS);
        for (int i = 0; i < OVF_POINTS; i++) begin
          feed_point(scm_pkg::data_t'($urandom_range(0, 65535)),
                     scm_pkg::data_t'(ovf_base + ((i * 37) % OVF_POINTS) * 3),
                     1'b0, 1'b0, '0, '0);
        end
        for (int i = 0; i < 4; i++) begin
          feed_point(scm_pkg::data_t'($urandom_range(0, 65535)),
                     scm_pkg::data_t'(ovf_base +
                                      (($urandom_range(0, scm_pkg::MAX_POINTS - 1) * 37)
                                       % OVF_POINTS) * 3),
                     i == 3, 1'b0, '0, '0);
        end
      end
      while (phase_items < 32) begin
        if ($urandom_range(0, 3) == 0) random_curve($urandom_range(9, 20));
        else random_curve($urandom_range(1, 8));
      end
      wait_for_results();
    end
    repeat (2 * scm_pkg::MAX_POINTS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
